@@ design/fssb_pkg.sv @@
// Package: S-box tables, stage record and word helpers for the Feistel S-box cipher.
`default_nettype none
package fssb_pkg;

  localparam int ROUNDS = 16;
  localparam int HALF_W = 32;
  localparam int BLOCK_W = 2 * HALF_W;

  typedef logic [7:0] byte_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef byte_t sbox_t [256];

  typedef struct packed {
    logic  dec;
    half_t left;
    half_t right;
  } stage_t;

  localparam sbox_t SBOX_FWD = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_t invert_sbox(sbox_t fwd);
    sbox_t inv;
    for (int v = 0; v < 256; v++) begin
      inv[fwd[v]] = byte_t'(v);
    end
    return inv;
  endfunction

  localparam sbox_t SBOX_INV = invert_sbox(SBOX_FWD);

  function automatic half_t sub_word(half_t w);
    half_t r;
    for (int n = 0; n < HALF_W / 8; n++) begin
      r[8*n +: 8] = SBOX_FWD[w[8*n +: 8]];
    end
    return r;
  endfunction

  function automatic half_t inv_sub_word(half_t w);
    half_t r;
    for (int n = 0; n < HALF_W / 8; n++) begin
      r[8*n +: 8] = SBOX_INV[w[8*n +: 8]];
    end
    return r;
  endfunction

  function automatic half_t rotl_word(half_t w, int amt);
    int a;
    a = amt % HALF_W;
    if (a == 0) begin
      return w;
    end
    return (w << a) | (w >> (HALF_W - a));
  endfunction

endpackage
`default_nettype wire

@@ design/feistel_sbox_block_cipher_unit.sv @@
// Top level: pipelined 16-round Feistel S-box cipher with key register and output skid stage.
//
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_func, in_block_in | block and operation in
//   out     | out_valid, out_stall, out_block_out     | processed block out
//   cfg     | cfg_valid, cfg_ready, cfg_data          | cipher key write
//
// One register stage per round, then the output register, which raises out_valid.
// One block enters per cycle while in_stall is low.
// in_stall comes from the skid register only, never from out_stall directly.
// Reset clears all valid bits and loads the substituted key of an all-zero key.
`default_nettype none
module feistel_sbox_block_cipher_unit
  import fssb_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_func,
  input  wire  [BLOCK_W-1:0]  in_block_in,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [BLOCK_W-1:0]  out_block_out,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [HALF_W-1:0]   cfg_data
);

  half_t  base_key_r;
  stage_t st_r     [ROUNDS];
  logic   st_vld_r [ROUNDS];
  stage_t rnd_in   [ROUNDS];
  stage_t rnd_out  [ROUNDS];
  half_t  rnd_key  [ROUNDS];

  logic         adv;
  logic         out_free;
  logic         out_valid_r;
  logic [BLOCK_W-1:0] out_r;
  logic         skid_valid_r;
  logic [BLOCK_W-1:0] skid_r;
  logic [BLOCK_W-1:0] pipe_blk;
  stage_t       last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_key_r <= sub_word('0);
    end else if (cfg_valid && cfg_ready) begin
      base_key_r <= sub_word(cfg_data);
    end
  end

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign rnd_in[0] = in_func ? {in_func, in_block_in[HALF_W-1:0], in_block_in[BLOCK_W-1:HALF_W]}
                             : {in_func, in_block_in};

  for (genvar k = 0; k < ROUNDS; k++) begin : g_round
    if (k > 0) begin : g_link
      assign rnd_in[k] = st_r[k-1];
    end

    assign rnd_key[k] = rnd_in[k].dec ? rotl_word(base_key_r, ROUNDS - 1 - k)
                                      : rotl_word(base_key_r, k);

    fssb_round u_round (
      .d         (rnd_in[k]),
      .round_key (rnd_key[k]),
      .q         (rnd_out[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k] <= 1'b0;
      end else if (adv) begin
        st_vld_r[k] <= (k == 0) ? in_valid : st_vld_r[k-1 < 0 ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= rnd_out[k];
      end
    end
  end

  assign last     = st_r[ROUNDS-1];
  assign pipe_blk = last.dec ? {last.right, last.left} : {last.left, last.right};
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= st_vld_r[ROUNDS-1];
    end else if (st_vld_r[ROUNDS-1]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (out_free) begin
      out_r <= pipe_blk;
    end else begin
      skid_r <= pipe_blk;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a block while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without an output stall");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && st_vld_r[ROUNDS-1]) |=> out_valid_r)
    else $error("block leaving the last round was dropped");

endmodule
`default_nettype wire

@@ design/fssb_round.sv @@
// One Feistel round: (L, R) -> (R, L xor InvSubWord(R xor key)).
`default_nettype none
module fssb_round
  import fssb_pkg::*;
(
  input  wire stage_t d,
  input  wire half_t  round_key,
  output stage_t      q
);

  assign q.dec   = d.dec;
  assign q.left  = d.right;
  assign q.right = d.left ^ inv_sub_word(d.right ^ round_key);

endmodule
`default_nettype wire
